// ===== src/mfs_pkg.sv =====
// Shared types and constants for the multilevel feedback scheduler.
// Used by the queue cells, the queue chain and the top level; no dependencies.
package mfs_pkg;

    localparam int LEVELS      = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int INDEX_W     = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic FUNC_ADD      = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    localparam logic MODE_FEEDBACK = 1'b0;

    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] need;
        logic [15:0] run;
    } entry_t;

    typedef enum logic [1:0] {
        QOP_NONE,
        QOP_INSERT,
        QOP_POP
    } qop_t;

    typedef struct packed {
        qop_t   op;
        entry_t entry;
    } qcmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_REINSERT
    } state_t;

endpackage

// ===== src/mfs_cell.sv =====
// One slot of the sorted ready queue; holds an entry and trades it with its neighbors.
// Depends on mfs_pkg for the entry and command types.
module mfs_cell (
    input  logic            aclk,
    input  logic            occupied_i,
    input  mfs_pkg::qcmd_t  cmd_i,
    input  logic            left_keep_i,
    input  mfs_pkg::entry_t left_entry_i,
    input  mfs_pkg::entry_t right_entry_i,
    output logic            keep_o,
    output mfs_pkg::entry_t entry_o
);

    mfs_pkg::entry_t entry_reg;
    mfs_pkg::entry_t entry_next;

    // An occupied slot of equal or higher priority stays ahead of the new entry.
    assign keep_o  = occupied_i && (entry_reg.prio >= cmd_i.entry.prio);
    assign entry_o = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        unique case (cmd_i.op)
            mfs_pkg::QOP_INSERT: begin
                if (!keep_o) begin
                    if (left_keep_i) begin
                        entry_next = cmd_i.entry;
                    end else begin
                        entry_next = left_entry_i;
                    end
                end
            end
            mfs_pkg::QOP_POP: begin
                entry_next = right_entry_i;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== src/mfs_queue.sv =====
// Sorted ready queue built as a row of mfs_cell slots plus the fill count.
// Depends on mfs_pkg and mfs_cell.
module mfs_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mfs_pkg::qcmd_t               cmd_i,
    output mfs_pkg::entry_t              head_o,
    output logic [mfs_pkg::COUNT_W-1:0]  count_o
);

    logic [mfs_pkg::COUNT_W-1:0] count_reg;
    logic [mfs_pkg::COUNT_W-1:0] count_next;

    mfs_pkg::entry_t                   entries [mfs_pkg::QUEUE_DEPTH];
    logic [mfs_pkg::QUEUE_DEPTH-1:0]   keep;

    genvar k;
    generate
        for (k = 0; k < mfs_pkg::QUEUE_DEPTH; k++) begin : g_cell
            logic            occupied;
            logic            left_keep;
            mfs_pkg::entry_t left_entry;
            mfs_pkg::entry_t right_entry;

            assign occupied = (mfs_pkg::COUNT_W'(k) < count_reg);

            if (k == 0) begin : g_first
                // The first slot takes the new entry whenever it yields its place.
                assign left_keep  = 1'b1;
                assign left_entry = cmd_i.entry;
            end else begin : g_inner
                assign left_keep  = keep[k-1];
                assign left_entry = entries[k-1];
            end

            if (k == mfs_pkg::QUEUE_DEPTH - 1) begin : g_last
                assign right_entry = entries[k];
            end else begin : g_mid
                assign right_entry = entries[k+1];
            end

            mfs_cell u_cell (
                .aclk          (aclk),
                .occupied_i    (occupied),
                .cmd_i         (cmd_i),
                .left_keep_i   (left_keep),
                .left_entry_i  (left_entry),
                .right_entry_i (right_entry),
                .keep_o        (keep[k]),
                .entry_o       (entries[k])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        unique case (cmd_i.op)
            mfs_pkg::QOP_INSERT: count_next = count_reg + mfs_pkg::COUNT_W'(1);
            mfs_pkg::QOP_POP:    count_next = count_reg - mfs_pkg::COUNT_W'(1);
            default:             count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign head_o  = entries[0];
    assign count_o = count_reg;

endmodule

// ===== src/multilevel_feedback_scheduler_core.sv =====
// Multilevel feedback queue scheduler: a sorted ready queue of process entries.
// Add items enqueue a process at the top level; dispatch items pop the head,
// run it for one round and reinsert it unless it has finished.
// Channels: s_* carries input items (s_tuser selects add or dispatch), m_* carries
// one result item per input item, cfg_* writes the one-bit scheduling mode.
// A result is registered and appears in the cycle after its item is taken.
// An add, or a dispatch that finishes its process or finds the queue empty, is done
// in one pass; a dispatch that reinserts its process holds off the next item while
// the popped head is put back by a second pass through the cell row.
// Inserts shift the cells behind the insert point by one slot, all at once.
// A new item is taken while the last result still waits, as long as the output
// register is emptied in the same cycle; a stalled receiver holds m_* steady and
// blocks further items once the output register is full.
// Reset (aresetn low, synchronous) empties the queue and selects feedback mode;
// no clearing pass is needed, since slots beyond the fill count are never read.
// Configuration writes are always accepted and should be made while idle.
// Depends on mfs_pkg and mfs_queue.
module multilevel_feedback_scheduler_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // proc_id[7:0], need_time[23:8]
    input  logic [0:0]  s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_id[7:0], ticks_run[11:8], run_total[27:12],
                                   // prio_after[35:28], finished[36], zero fill [39:37]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data   // sched_mode[0]
);

    mfs_pkg::state_t state_reg, state_next;
    logic            mode_reg;
    logic            out_valid_reg, out_valid_next;
    logic [36:0]     out_data_reg, out_data_next;
    logic [1:0]      out_status_reg, out_status_next;
    mfs_pkg::entry_t pend_reg, pend_next;

    mfs_pkg::qcmd_t               qcmd;
    mfs_pkg::entry_t              head;
    logic [mfs_pkg::COUNT_W-1:0]  count;

    logic        accept;
    logic [7:0]  in_id;
    logic [15:0] in_need;
    logic [15:0] need_fixed;
    logic        queue_full;
    logic        queue_empty;

    logic        slice_scaled;
    logic [7:0]  shift_amt;
    logic [15:0] slice;
    logic [15:0] left;
    logic [15:0] ticks;
    logic [15:0] run_new;
    logic        done;
    logic [7:0]  prio_new;
    logic [3:0]  ticks_rep;

    mfs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd_i   (qcmd),
        .head_o  (head),
        .count_o (count)
    );

    assign in_id       = s_tdata[7:0];
    assign in_need     = s_tdata[23:8];
    assign need_fixed  = (in_need == 16'd0) ? 16'd1 : in_need;
    assign queue_full  = (count == mfs_pkg::COUNT_W'(mfs_pkg::QUEUE_DEPTH));
    assign queue_empty = (count == '0);

    assign s_tready  = (state_reg == mfs_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Round arithmetic on the current head entry.
    assign slice_scaled = (mode_reg == mfs_pkg::MODE_FEEDBACK) && (head.prio >= 8'd1)
                          && (head.prio <= 8'(mfs_pkg::LEVELS));
    assign shift_amt    = 8'(mfs_pkg::LEVELS) - head.prio;
    assign slice        = slice_scaled ? (16'd1 << shift_amt) : 16'd1;
    assign left         = (head.need > head.run) ? (head.need - head.run) : 16'd0;
    assign ticks        = (slice < left) ? slice : left;
    assign run_new      = head.run + ticks;
    assign done         = (run_new >= head.need);
    assign ticks_rep    = (ticks > 16'd15) ? 4'd15 : ticks[3:0];

    always_comb begin
        prio_new = head.prio;
        if (!done) begin
            if (mode_reg == mfs_pkg::MODE_FEEDBACK) begin
                if (head.prio > 8'd1) begin
                    prio_new = head.prio - 8'd1;
                end
            end else begin
                if (head.prio < 8'd255) begin
                    prio_new = head.prio + 8'd1;
                end
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        pend_next       = pend_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        qcmd.op         = mfs_pkg::QOP_NONE;
        qcmd.entry      = pend_reg;

        unique case (state_reg)
            mfs_pkg::ST_IDLE: begin
                if (accept) begin
                    out_valid_next = 1'b1;
                    if (s_tuser[0] == mfs_pkg::FUNC_ADD) begin
                        out_data_next = {1'b0, 8'(mfs_pkg::LEVELS), 16'd0, 4'd0, in_id};
                        if (queue_full) begin
                            out_status_next = mfs_pkg::STATUS_FULL;
                        end else begin
                            out_status_next = mfs_pkg::STATUS_DONE;
                            qcmd.op         = mfs_pkg::QOP_INSERT;
                            qcmd.entry      = '{id: in_id, prio: 8'(mfs_pkg::LEVELS),
                                                need: need_fixed, run: 16'd0};
                        end
                    end else if (queue_empty) begin
                        out_data_next   = '0;
                        out_status_next = mfs_pkg::STATUS_EMPTY;
                    end else begin
                        out_data_next   = {done, prio_new, run_new, ticks_rep, head.id};
                        out_status_next = mfs_pkg::STATUS_DONE;
                        qcmd.op         = mfs_pkg::QOP_POP;
                        pend_next       = '{id: head.id, prio: prio_new,
                                            need: head.need, run: run_new};
                        if (!done) begin
                            state_next = mfs_pkg::ST_REINSERT;
                        end
                    end
                end
            end
            mfs_pkg::ST_REINSERT: begin
                qcmd.op    = mfs_pkg::QOP_INSERT;
                qcmd.entry = pend_reg;
                state_next = mfs_pkg::ST_IDLE;
            end
            default: begin
                state_next = mfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mfs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            mode_reg      <= mfs_pkg::MODE_FEEDBACK;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                mode_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg       <= pend_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== test/multilevel_feedback_scheduler_core_test.sv =====
// Self-checking testbench for multilevel_feedback_scheduler_core: a directed table,
// then randomized add/dispatch traffic checked against a shadow ready queue.
// Depends on mfs_pkg and the scheduler RTL; reads no files.
`timescale 1ns / 1ps

module multilevel_feedback_scheduler_core_test;

    localparam logic MODE_SINGLE_TICK = 1'b1;
    localparam int   CYCLE_LIMIT      = 400000;
    localparam int   LONG_HOLD        = 250;

    typedef struct packed {
        logic [7:0]  id;
        logic [3:0]  ticks;
        logic [15:0] run;
        logic [7:0]  prio;
        logic        fin;
        logic [1:0]  status;
    } round_result_t;

    typedef struct {
        logic          func;
        logic [7:0]    id;
        logic [15:0]   need;
        bit            fixed;
        round_result_t res;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // proc_id[7:0], need_time[23:8]
    logic [0:0]  s_tuser;   // func[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // out_id[7:0], ticks_run[11:8], run_total[27:12],
                            // prio_after[35:28], finished[36]
    logic [1:0]  m_tuser;   // status[1:0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_data;  // sched_mode[0]

    mfs_pkg::entry_t ready_q[$];
    logic            mode_shadow;
    round_result_t   pending_rounds[$];
    stim_row_t       dir_tab[$];
    int              bad_rounds = 0;
    int              cycles = 0;
    bit              no_idle;
    bit              hold_req;

    multilevel_feedback_scheduler_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // A new or reinserted entry goes behind every entry of equal or higher priority.
    function automatic void requeue(mfs_pkg::entry_t e);
        int pos;
        pos = 0;
        while (pos < ready_q.size() && ready_q[pos].prio >= e.prio)
            pos++;
        ready_q.insert(pos, e);
    endfunction

    function automatic round_result_t schedule_round(logic func, logic [7:0] pid,
                                                     logic [15:0] need_in);
        round_result_t   r;
        mfs_pkg::entry_t head;
        int unsigned     slice, left, ticks, run, need, prio;
        logic            done;
        r = '0;
        if (func == mfs_pkg::FUNC_ADD) begin
            r.id   = pid;
            r.prio = 8'(mfs_pkg::LEVELS);
            if (ready_q.size() >= mfs_pkg::QUEUE_DEPTH) begin
                r.status = mfs_pkg::STATUS_FULL;
            end else begin
                head.id   = pid;
                head.prio = 8'(mfs_pkg::LEVELS);
                head.need = (need_in == 16'd0) ? 16'd1 : need_in;
                head.run  = '0;
                requeue(head);
                r.status = mfs_pkg::STATUS_DONE;
            end
        end else if (ready_q.size() == 0) begin
            r.status = mfs_pkg::STATUS_EMPTY;
        end else begin
            head  = ready_q.pop_front();
            prio  = head.prio;
            need  = head.need;
            run   = head.run;
            slice = 1;
            // Priorities above the top level only come from single-tick rounds.
            if (mode_shadow == mfs_pkg::MODE_FEEDBACK && prio >= 1
                    && prio <= mfs_pkg::LEVELS)
                slice = 1 << (mfs_pkg::LEVELS - prio);
            left  = (need > run) ? need - run : 0;
            ticks = (slice < left) ? slice : left;
            run   = run + ticks;
            done  = (run >= need);
            if (!done) begin
                if (mode_shadow == mfs_pkg::MODE_FEEDBACK) begin
                    if (prio > 1)
                        prio--;
                end else if (prio < 255) begin
                    prio++;
                end
                head.prio = 8'(prio);
                head.run  = 16'(run);
                requeue(head);
            end
            r.id     = head.id;
            r.ticks  = (ticks > 15) ? 4'd15 : 4'(ticks);
            r.run    = 16'(run);
            r.prio   = 8'(prio);
            r.fin    = done;
            r.status = mfs_pkg::STATUS_DONE;
        end
        return r;
    endfunction

    function automatic round_result_t mk_result(logic [7:0] id, logic [3:0] ticks,
                                                logic [15:0] run, logic [7:0] prio,
                                                logic fin, logic [1:0] status);
        round_result_t r;
        r.id     = id;
        r.ticks  = ticks;
        r.run    = run;
        r.prio   = prio;
        r.fin    = fin;
        r.status = status;
        return r;
    endfunction

    function automatic stim_row_t stim_row(logic func, logic [7:0] id, logic [15:0] need,
                                           bit fixed, round_result_t res);
        stim_row_t row;
        row.func  = func;
        row.id    = id;
        row.need  = need;
        row.fixed = fixed;
        row.res   = res;
        return row;
    endfunction

    // Offers one item, waits for the handshake and records what it should produce.
    task automatic send_item(logic func, logic [7:0] id, logic [15:0] need,
                             bit fixed, round_result_t fixed_res);
        int            gap;
        round_result_t r;
        gap = (!no_idle && $urandom_range(7) == 0) ? $urandom_range(1, 19) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {need, id};
        do @(posedge aclk); while (!s_tready);
        r = schedule_round(func, id, need);
        pending_rounds.push_back(fixed ? fixed_res : r);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_rounds.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_mode(logic mode);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        mode_shadow = mode;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic in the current mode; enqueued needs stay small so processes
    // finish, while adds that hit a full queue carry needs from the whole range.
    task automatic run_mix(int count, int add_pct, int pause_at);
        logic        func;
        logic [15:0] need;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at)
                wait_drained();
            func = ($urandom_range(99) < add_pct) ? mfs_pkg::FUNC_ADD
                                                  : mfs_pkg::FUNC_DISPATCH;
            if (ready_q.size() >= mfs_pkg::QUEUE_DEPTH)
                need = 16'($urandom_range(1, 65535));
            else if ($urandom_range(19) == 0)
                need = 16'($urandom_range(25, 300));
            else
                need = 16'($urandom_range(1, 24));
            send_item(func, 8'($urandom_range(255)), need, 1'b0, '0);
        end
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin : ready_gen
            int stall_left;
            int hold_left;
            bit hold_done;
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(15) == 0)
                    stall_left = $urandom_range(1, 19);
            end
        end
    end

    always @(posedge aclk) begin
        round_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = mk_result(m_tdata[7:0], m_tdata[11:8], m_tdata[27:12],
                            m_tdata[35:28], m_tdata[36], m_tuser);
            if (pending_rounds.size() == 0) begin
                bad_rounds++;
                if (bad_rounds <= 10)
                    $display("unexpected result item: %p", got);
            end else begin
                want = pending_rounds.pop_front();
                if (got.id !== want.id || got.ticks !== want.ticks || got.run !== want.run
                        || got.prio !== want.prio || got.fin !== want.fin
                        || got.status !== want.status) begin
                    bad_rounds++;
                    if (bad_rounds <= 10)
                        $display("result mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = mfs_pkg::FUNC_ADD;
        cfg_valid   = 1'b0;
        cfg_data    = mfs_pkg::MODE_FEEDBACK;
        mode_shadow = mfs_pkg::MODE_FEEDBACK;
        no_idle     = 1'b0;
        hold_req    = 1'b0;

        // Rows with a typed result can be read off directly; the slice ladder
        // of two interleaved processes in the middle goes through the predictor.
        dir_tab.push_back(stim_row(mfs_pkg::FUNC_DISPATCH, 8'h00, 16'd0, 1'b1,
                                   mk_result(8'h00, 4'd0, 16'd0, 8'd0, 1'b0,
                                             mfs_pkg::STATUS_EMPTY)));
        dir_tab.push_back(stim_row(mfs_pkg::FUNC_ADD, 8'h00, 16'd0, 1'b1,
                                   mk_result(8'h00, 4'd0, 16'd0, 8'(mfs_pkg::LEVELS),
                                             1'b0, mfs_pkg::STATUS_DONE)));
        dir_tab.push_back(stim_row(mfs_pkg::FUNC_ADD, 8'hFF, 16'd1, 1'b1,
                                   mk_result(8'hFF, 4'd0, 16'd0, 8'(mfs_pkg::LEVELS),
                                             1'b0, mfs_pkg::STATUS_DONE)));
        dir_tab.push_back(stim_row(mfs_pkg::FUNC_DISPATCH, 8'h00, 16'd0, 1'b1,
                                   mk_result(8'h00, 4'd1, 16'd1, 8'(mfs_pkg::LEVELS),
                                             1'b1, mfs_pkg::STATUS_DONE)));
        dir_tab.push_back(stim_row(mfs_pkg::FUNC_DISPATCH, 8'hFF, 16'hFFFF, 1'b1,
                                   mk_result(8'hFF, 4'd1, 16'd1, 8'(mfs_pkg::LEVELS),
                                             1'b1, mfs_pkg::STATUS_DONE)));
        dir_tab.push_back(stim_row(mfs_pkg::FUNC_DISPATCH, 8'h00, 16'd0, 1'b1,
                                   mk_result(8'h00, 4'd0, 16'd0, 8'd0, 1'b0,
                                             mfs_pkg::STATUS_EMPTY)));
        dir_tab.push_back(stim_row(mfs_pkg::FUNC_ADD, 8'h5A, 16'd20, 1'b1,
                                   mk_result(8'h5A, 4'd0, 16'd0, 8'(mfs_pkg::LEVELS),
                                             1'b0, mfs_pkg::STATUS_DONE)));
        dir_tab.push_back(stim_row(mfs_pkg::FUNC_ADD, 8'hA5, 16'd16, 1'b1,
                                   mk_result(8'hA5, 4'd0, 16'd0, 8'(mfs_pkg::LEVELS),
                                             1'b0, mfs_pkg::STATUS_DONE)));
        for (int k = 0; k < 10; k++)
            dir_tab.push_back(stim_row(mfs_pkg::FUNC_DISPATCH, 8'(k), 16'(k), 1'b0, '0));
        dir_tab.push_back(stim_row(mfs_pkg::FUNC_DISPATCH, 8'h00, 16'd0, 1'b1,
                                   mk_result(8'h00, 4'd0, 16'd0, 8'd0, 1'b0,
                                             mfs_pkg::STATUS_EMPTY)));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_mode(mfs_pkg::MODE_FEEDBACK);
        foreach (dir_tab[i])
            send_item(dir_tab[i].func, dir_tab[i].id, dir_tab[i].need,
                      dir_tab[i].fixed, dir_tab[i].res);

        // Fill the queue, overflow it with the widest need, then drain it.
        for (int k = 0; k < mfs_pkg::QUEUE_DEPTH; k++)
            send_item(mfs_pkg::FUNC_ADD, 8'($urandom_range(255)), 16'd1, 1'b0, '0);
        send_item(mfs_pkg::FUNC_ADD, 8'($urandom_range(255)), 16'hFFFF, 1'b0, '0);
        repeat (mfs_pkg::QUEUE_DEPTH + 1)
            send_item(mfs_pkg::FUNC_DISPATCH, 8'($urandom_range(255)), 16'($urandom),
                      1'b0, '0);

        // One process keeps the head in single-tick mode and climbs until its
        // priority saturates; back in feedback mode it then runs one tick at a time.
        write_mode(MODE_SINGLE_TICK);
        send_item(mfs_pkg::FUNC_ADD, 8'hC3, 16'd280, 1'b0, '0);
        repeat (270)
            send_item(mfs_pkg::FUNC_DISPATCH, 8'($urandom_range(255)), 16'($urandom),
                      1'b0, '0);

        write_mode(mfs_pkg::MODE_FEEDBACK);
        hold_req = 1'b1;
        run_mix(160, 55, -1);
        write_mode(MODE_SINGLE_TICK);
        run_mix(160, 60, -1);
        write_mode(mfs_pkg::MODE_FEEDBACK);
        run_mix(150, 70, 75);
        write_mode(MODE_SINGLE_TICK);
        run_mix(100, 40, -1);
        write_mode(mfs_pkg::MODE_FEEDBACK);
        no_idle = 1'b1;
        run_mix(100, 50, -1);

        wait_drained();
        repeat (10) @(negedge aclk);
        if (bad_rounds == 0 && pending_rounds.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== multilevel_feedback_scheduler_core.f =====
src/mfs_pkg.sv
src/mfs_cell.sv
src/mfs_queue.sv
src/multilevel_feedback_scheduler_core.sv
test/multilevel_feedback_scheduler_core_test.sv
